/* design/sse_pkg.sv */
// ----------------------------------------------------------------------------
// sse_pkg: shared types and constants of the sorted set engine
// Command codes, field widths, controller states and the control bundle
// that the controller broadcasts to the row of cells.
// ----------------------------------------------------------------------------
package sse_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned CMD_W  = 3;
    localparam int unsigned CNT_W  = 9;
    localparam int unsigned POS_W  = 8;
    localparam int unsigned CAP_W  = 9;

    localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

    localparam logic [CMD_W-1:0] CMD_INSERT    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_LOOKUP    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP       = 3'd3;
    localparam logic [CMD_W-1:0] CMD_ITER_INIT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_ITER_NEXT = 3'd5;

    typedef enum logic {
        ST_IDLE,
        ST_UPD
    } t_state;

    typedef struct packed {
        logic                     cmp;
        logic                     ins;
        logic                     rem;
        logic signed [DATA_W-1:0] key;
    } t_cell_ctl;

endpackage

/* design/sse_if.sv */
// ----------------------------------------------------------------------------
// sse_if: item channels of the sorted set engine
// Command channel and result channel, each a valid/ready handshake.
// ----------------------------------------------------------------------------
interface sse_cmd_if;
    logic                             valid;
    logic                             ready;
    logic [sse_pkg::CMD_W-1:0]        cmd;
    logic signed [sse_pkg::DATA_W-1:0] value;

    modport source (output valid, output cmd, output value, input ready);
    modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sse_res_if;
    logic                             valid;
    logic                             ready;
    logic                             ok;
    logic                             found;
    logic [sse_pkg::POS_W-1:0]        position;
    logic signed [sse_pkg::DATA_W-1:0] read_value;
    logic [sse_pkg::CNT_W-1:0]        count;
    logic                             is_empty;

    modport source (output valid, output ok, output found, output position,
                    output read_value, output count, output is_empty, input ready);
    modport sink   (input valid, input ok, input found, input position,
                    input read_value, input count, input is_empty, output ready);
endinterface

/* design/sse_cell.sv */
// ----------------------------------------------------------------------------
// sse_cell: one slot of the sorted element row
// Holds one element, compares it with the broadcast key and shifts toward
// a neighbor on insert or remove.
// ----------------------------------------------------------------------------
module sse_cell (
    input  logic                             i_clk,
    input  sse_pkg::t_cell_ctl               i_ctl,
    input  logic                             i_occ,
    input  logic                             i_sel,
    input  logic                             i_left_lt,
    input  logic signed [sse_pkg::DATA_W-1:0] i_left_val,
    input  logic signed [sse_pkg::DATA_W-1:0] i_right_val,
    output logic signed [sse_pkg::DATA_W-1:0] o_val,
    output logic                             o_lt,
    output logic                             o_eq,
    output logic                             o_sel
);

    logic signed [sse_pkg::DATA_W-1:0] r_val;
    logic                              r_lt;
    logic                              r_eq;
    logic                              r_sel;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt  <= i_occ && (r_val < i_ctl.key);
            r_eq  <= i_occ && (r_val == i_ctl.key);
            r_sel <= i_occ && i_sel;
        end
        // cells below the insertion point keep their element
        if (i_ctl.ins && !r_lt) begin
            if (i_left_lt) begin
                r_val <= i_ctl.key;
            end else begin
                r_val <= i_left_val;
            end
        end else if (i_ctl.rem && !r_lt) begin
            r_val <= i_right_val;
        end
    end

    assign o_val = r_val;
    assign o_lt  = r_lt;
    assign o_eq  = r_eq;
    assign o_sel = r_sel;

endmodule

/* design/sorted_set_engine_top.sv */
// ----------------------------------------------------------------------------
// sorted_set_engine_top: sorted set of distinct signed 32-bit values
// result: becomes valid at the commit in the update state that follows the accept;
//   the commit waits while an earlier result waits on the output channel
// one item at a time: a compare step across the cell row at accept, then a
//   shift/commit step; a waiting result holds the commit and no new item is taken
// reset: count, iterator and result valid clear, capacity returns to 256;
//   element cells are not cleared and need no clearing pass
// ----------------------------------------------------------------------------
module sorted_set_engine_top #(
    parameter int unsigned DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sse_cmd_if.sink                    i_in,
    sse_res_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [2:0]                 paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    localparam int unsigned CNT_MAX = (1 << sse_pkg::CNT_W) - 1;
    localparam logic [sse_pkg::CNT_W-1:0] LIM =
        sse_pkg::CNT_W'((DEPTH > CNT_MAX) ? CNT_MAX : DEPTH);

    sse_pkg::t_state r_state, n_state;

    logic [sse_pkg::CMD_W-1:0]         r_cmd;
    logic signed [sse_pkg::DATA_W-1:0] r_value;
    logic [sse_pkg::CNT_W-1:0]         r_count, n_count;
    logic [sse_pkg::CNT_W-1:0]         r_iter, n_iter;
    logic [sse_pkg::CAP_W-1:0]         r_cap;

    logic                              r_out_valid;
    logic                              r_ok, n_ok;
    logic                              r_found, n_found;
    logic [sse_pkg::POS_W-1:0]         r_pos, n_pos;
    logic signed [sse_pkg::DATA_W-1:0] r_rd, n_rd;

    logic                              w_in_acc;
    logic                              w_ready;
    logic                              w_commit;
    logic                              w_any_eq;
    logic                              w_room;
    logic [sse_pkg::CNT_W-1:0]         w_bound;
    logic [sse_pkg::CNT_W-1:0]         w_addr;
    logic [sse_pkg::POS_W-1:0]         w_enc_pos;
    logic signed [sse_pkg::DATA_W-1:0] w_sel_val;
    sse_pkg::t_cell_ctl                w_ctl;

    logic [DEPTH-1:0]                  w_occ;
    logic [DEPTH-1:0]                  w_sel;
    logic [DEPTH-1:0]                  w_lt;
    logic [DEPTH-1:0]                  w_eq;
    logic [DEPTH-1:0]                  w_hit;
    logic signed [sse_pkg::DATA_W-1:0] w_val [DEPTH];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= sse_pkg::CAP_RESET;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            r_cap <= pwdata[sse_pkg::CAP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (!paddr[2]) begin
            prdata = {{(32 - sse_pkg::CAP_W){1'b0}}, r_cap};
        end
    end

    // ---------------- controller ----------------
    assign w_in_acc = i_in.valid && w_ready;
    assign i_in.ready = w_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sse_pkg::ST_IDLE: begin
                if (w_in_acc) begin
                    n_state = sse_pkg::ST_UPD;
                end
            end
            sse_pkg::ST_UPD: begin
                if (w_commit) begin
                    n_state = sse_pkg::ST_IDLE;
                end
            end
            default: n_state = sse_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        w_ready  = 1'b0;
        w_commit = 1'b0;
        unique case (r_state)
            sse_pkg::ST_IDLE: w_ready = 1'b1;
            sse_pkg::ST_UPD:  w_commit = !r_out_valid || o_out.ready;
            default: begin
                w_ready  = 1'b0;
                w_commit = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sse_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd   <= i_in.cmd;
            r_value <= i_in.value;
        end
    end

    // read address for pop and iterator next, picked at accept
    assign w_addr = (i_in.cmd == sse_pkg::CMD_POP) ? (r_count - 1'b1) : r_iter;

    assign w_bound = (r_cap < LIM) ? r_cap : LIM;
    assign w_room  = r_count < w_bound;

    always_comb begin
        w_ctl.cmp = w_in_acc;
        w_ctl.key = w_in_acc ? i_in.value : r_value;
        w_ctl.ins = w_commit && (r_cmd == sse_pkg::CMD_INSERT) && w_room && !w_any_eq;
        w_ctl.rem = w_commit && (r_cmd == sse_pkg::CMD_REMOVE) && w_any_eq;
    end

    // ---------------- row of cells ----------------
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        logic                              w_left_lt;
        logic signed [sse_pkg::DATA_W-1:0] w_left_val;
        logic signed [sse_pkg::DATA_W-1:0] w_right_val;

        assign w_occ[g] = 32'(g) < 32'(r_count);
        assign w_sel[g] = 32'(g) == 32'(w_addr);

        if (g == 0) begin : g_first
            assign w_left_lt  = 1'b1;
            assign w_left_val = w_val[g];
        end else begin : g_mid
            assign w_left_lt  = w_lt[g-1];
            assign w_left_val = w_val[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_val = w_val[g];
        end else begin : g_inner
            assign w_right_val = w_val[g+1];
        end

        sse_cell u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_occ       (w_occ[g]),
            .i_sel       (w_sel[g]),
            .i_left_lt   (w_left_lt),
            .i_left_val  (w_left_val),
            .i_right_val (w_right_val),
            .o_val       (w_val[g]),
            .o_lt        (w_lt[g]),
            .o_eq        (w_eq[g]),
            .o_sel       (w_hit[g])
        );
    end

    // match flags are one-hot at most, so encode and read out by or-ing
    always_comb begin
        w_enc_pos = '0;
        w_sel_val = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_eq[i]) begin
                w_enc_pos = w_enc_pos | sse_pkg::POS_W'(i);
            end
            if (w_hit[i]) begin
                w_sel_val = w_sel_val | w_val[i];
            end
        end
    end

    assign w_any_eq = |w_eq;

    // ---------------- result and state update ----------------
    always_comb begin
        n_ok    = 1'b0;
        n_found = 1'b0;
        n_pos   = '0;
        n_rd    = '0;
        n_count = r_count;
        n_iter  = r_iter;
        unique case (r_cmd)
            sse_pkg::CMD_INSERT: begin
                n_ok = w_room;
                if (w_room && !w_any_eq) begin
                    n_count = r_count + 1'b1;
                end
            end
            sse_pkg::CMD_REMOVE: begin
                n_ok    = w_any_eq;
                n_found = w_any_eq;
                if (w_any_eq) begin
                    n_count = r_count - 1'b1;
                end
            end
            sse_pkg::CMD_LOOKUP: begin
                n_found = w_any_eq;
                n_pos   = w_enc_pos;
            end
            sse_pkg::CMD_POP: begin
                if (r_count != '0) begin
                    n_ok    = 1'b1;
                    n_rd    = w_sel_val;
                    n_count = r_count - 1'b1;
                end
            end
            sse_pkg::CMD_ITER_INIT: begin
                n_iter = '0;
            end
            sse_pkg::CMD_ITER_NEXT: begin
                if (r_iter < r_count) begin
                    n_ok   = 1'b1;
                    n_rd   = w_sel_val;
                    n_iter = r_iter + 1'b1;
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_count     <= n_count;
                r_iter      <= n_iter;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_commit) begin
            r_ok    <= n_ok;
            r_found <= n_found;
            r_pos   <= n_pos;
            r_rd    <= n_rd;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.ok         = r_ok;
    assign o_out.found      = r_found;
    assign o_out.position   = r_pos;
    assign o_out.read_value = r_rd;
    assign o_out.count      = r_count;
    assign o_out.is_empty   = (r_count == '0);

    // ---------------- assertions ----------------
    a_lt_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::ST_UPD) |-> (((w_lt >> 1) & ~w_lt) == '0))
        else $error("less-than flags are not a prefix of the row");

    a_eq_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::ST_UPD) |-> $onehot0(w_eq))
        else $error("value matched more than one cell");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sse_pkg::ST_UPD) |-> $onehot0(w_hit))
        else $error("read select hit more than one cell");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("element count beyond the row length");

    a_ins_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.ins |=> (r_count == $past(r_count) + 1'b1))
        else $error("insert did not raise the count");

endmodule
